// ===== sv/gsdw_pkg.sv =====
// shared types, codes and constants of the grid steepest descent walk
`timescale 1ns / 1ps
`default_nettype none

package gsdw_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int HEIGHT_BITS_DEF = 16;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int ELEV_W  = 16;
    localparam int STEP_W  = 6;
    localparam int DIM_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int NB_W    = 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WALK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 2'd3;

    localparam logic [NB_W-1:0] NB_LAST = 3'd7;

    typedef enum logic [1:0] {
        DELTA_ZERO  = 2'b00,
        DELTA_PLUS  = 2'b01,
        DELTA_MINUS = 2'b11
    } t_delta;

    // neighbor order nw, w, sw, n, s, ne, e, se
    localparam t_delta NB_DROW [8] = '{DELTA_MINUS, DELTA_ZERO, DELTA_PLUS, DELTA_MINUS,
                                       DELTA_PLUS, DELTA_MINUS, DELTA_ZERO, DELTA_PLUS};
    localparam t_delta NB_DCOL [8] = '{DELTA_MINUS, DELTA_MINUS, DELTA_MINUS, DELTA_ZERO,
                                       DELTA_ZERO, DELTA_PLUS, DELTA_PLUS, DELTA_PLUS};

    typedef enum logic [1:0] {
        EMIT_NONE  = 2'd0,
        EMIT_TRACE = 2'd1,
        EMIT_END   = 2'd2,
        EMIT_FAULT = 2'd3
    } t_emit;

    typedef struct packed {
        logic            load;
        logic            start;
        logic            rd_center;
        logic            scan;
        logic [NB_W-1:0] nb_idx;
        logic            move;
        t_emit           emit;
    } t_dp_cmd;

    typedef struct packed {
        logic start_fault;
        logic has_lower;
        logic at_limit;
        logic trace_on;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/gsdw_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module gsdw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/gsdw_ctrl.sv =====
// walk sequencer: input handshake, neighbor scan order and result scheduling
`timescale 1ns / 1ps
`default_nettype none

module gsdw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_op,
    input  wire gsdw_pkg::t_dp_stat i_stat,
    output gsdw_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CENTER = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_DECIDE = 8'b0001_0000,
        S_TRACE  = 8'b0010_0000,
        S_END    = 8'b0100_0000,
        S_FAULT  = 8'b1000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [gsdw_pkg::NB_W-1:0]   r_nb, n_nb;
    gsdw_pkg::t_dp_cmd           cmd;

    always_comb begin
        n_state = r_state;
        n_nb    = r_nb;
        cmd     = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == gsdw_pkg::OP_WALK) begin
                        cmd.start = 1'b1;
                        n_state   = i_stat.start_fault ? S_FAULT : S_CENTER;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_CENTER: begin
                cmd.rd_center = 1'b1;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan   = 1'b1;
                cmd.nb_idx = r_nb;
                n_nb       = r_nb + 3'd1;
                if (r_nb == gsdw_pkg::NB_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_stat.has_lower || i_stat.at_limit) begin
                    n_state = S_END;
                end else begin
                    cmd.move = 1'b1;
                    n_state  = i_stat.trace_on ? S_TRACE : S_SCAN;
                end
            end
            S_TRACE: begin
                if (i_stat.out_free) begin
                    cmd.emit = gsdw_pkg::EMIT_TRACE;
                    n_state  = S_SCAN;
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    cmd.emit = gsdw_pkg::EMIT_END;
                    n_state  = S_IDLE;
                end
            end
            S_FAULT: begin
                if (i_stat.out_free) begin
                    cmd.emit = gsdw_pkg::EMIT_FAULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nb    <= '0;
        end else begin
            r_state <= n_state;
            r_nb    <= n_nb;
        end
    end

    assign o_cmd = cmd;

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit != gsdw_pkg::EMIT_NONE) |-> i_stat.out_free)
        else $error("result issued while output word occupied");

    a_decide_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> $past(r_state == S_DRAIN))
        else $error("decision reached without finishing the scan");

    a_fault_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.start && i_stat.start_fault) |=> (r_state == S_FAULT))
        else $error("out of grid start did not take the fault path");

endmodule

`default_nettype wire

// ===== sv/gsdw_dpath.sv =====
// datapath: config registers, height memory, neighbor compare and output word
`timescale 1ns / 1ps
`default_nettype none

module gsdw_dpath #(
    parameter int MAX_ROWS    = gsdw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = gsdw_pkg::MAX_COLS_DEF,
    parameter int HEIGHT_BITS = gsdw_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire gsdw_pkg::t_dp_cmd                  i_cmd,
    output gsdw_pkg::t_dp_stat                      o_stat,
    input  wire logic [gsdw_pkg::ROW_W-1:0]         i_row_index,
    input  wire logic [gsdw_pkg::COL_W-1:0]         i_col_index,
    input  wire logic [gsdw_pkg::ELEV_W-1:0]        i_elevation,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [gsdw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gsdw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic      [gsdw_pkg::ROW_W-1:0]         o_cell_row,
    output logic      [gsdw_pkg::COL_W-1:0]         o_cell_col,
    output logic      [gsdw_pkg::ELEV_W-1:0]        o_cell_height,
    output logic      [gsdw_pkg::STEP_W-1:0]        o_step_count,
    output logic                                    o_truncated,
    output logic                                    o_fault,
    output logic                                    o_last
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [gsdw_pkg::DIM_W-1:0] ROW_CAP =
        (MAX_ROWS < 64) ? gsdw_pkg::DIM_W'(MAX_ROWS) : 7'd64;
    localparam logic [gsdw_pkg::DIM_W-1:0] COL_CAP =
        (MAX_COLS < 64) ? gsdw_pkg::DIM_W'(MAX_COLS) : 7'd64;
    localparam logic [10:0] ROW_LIMIT = 11'(MAX_ROWS);
    localparam logic [10:0] COL_LIMIT = 11'(MAX_COLS);
    localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_COLS);

    function automatic logic [gsdw_pkg::DIM_W-1:0] clamp_dim(
        input logic [gsdw_pkg::DIM_W-1:0] v,
        input logic [gsdw_pkg::DIM_W-1:0] cap
    );
        logic [gsdw_pkg::DIM_W-1:0] res;
        if (v == '0) begin
            res = 7'd1;
        end else if (v > cap) begin
            res = cap;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [gsdw_pkg::ROW_W-1:0] row,
        input logic [gsdw_pkg::COL_W-1:0] col
    );
        return ADDR_W'(row) * ROW_PITCH + ADDR_W'(col);
    endfunction

    // configuration
    logic [gsdw_pkg::DIM_W-1:0]  r_rows_eff, r_cols_eff;
    logic                        r_trace;
    logic [gsdw_pkg::STEP_W-1:0] r_max_steps;

    // walk state
    logic [gsdw_pkg::ROW_W-1:0]  r_cur_row, r_best_row, r_pend_row;
    logic [gsdw_pkg::COL_W-1:0]  r_cur_col, r_best_col, r_pend_col;
    logic [HEIGHT_BITS-1:0]      r_cur_h, r_best_h;
    logic [gsdw_pkg::STEP_W-1:0] r_moves;
    logic                        r_pend_valid, r_pend_center;

    // output word
    logic                        r_out_valid;
    logic [gsdw_pkg::ROW_W-1:0]  r_out_row;
    logic [gsdw_pkg::COL_W-1:0]  r_out_col;
    logic [gsdw_pkg::ELEV_W-1:0] r_out_h;
    logic [gsdw_pkg::STEP_W-1:0] r_out_steps;
    logic                        r_out_trunc, r_out_fault, r_out_last;

    logic                        out_free, has_lower, load_ok, nb_ok, row_ok, col_ok;
    logic [gsdw_pkg::ROW_W-1:0]  nb_row;
    logic [gsdw_pkg::COL_W-1:0]  nb_col;
    logic [gsdw_pkg::DIM_W-1:0]  row_p1, col_p1;
    gsdw_pkg::t_delta            dr, dc;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_addr;
    logic [HEIGHT_BITS-1:0]      ram_rdata;

    assign out_free  = !r_out_valid || !i_stall;
    assign has_lower = (r_best_row != r_cur_row) || (r_best_col != r_cur_col);
    assign load_ok   = (11'(i_row_index) < ROW_LIMIT) && (11'(i_col_index) < COL_LIMIT);

    assign o_stat.start_fault = ({1'b0, i_row_index} >= r_rows_eff) ||
                                ({1'b0, i_col_index} >= r_cols_eff);
    assign o_stat.has_lower   = has_lower;
    assign o_stat.at_limit    = (r_moves >= r_max_steps);
    assign o_stat.trace_on    = r_trace;
    assign o_stat.out_free    = out_free;

    assign dr     = gsdw_pkg::NB_DROW[i_cmd.nb_idx];
    assign dc     = gsdw_pkg::NB_DCOL[i_cmd.nb_idx];
    assign row_p1 = {1'b0, r_cur_row} + 7'd1;
    assign col_p1 = {1'b0, r_cur_col} + 7'd1;

    always_comb begin
        case (dr)
            gsdw_pkg::DELTA_MINUS: begin
                row_ok = (r_cur_row != '0);
                nb_row = r_cur_row - 6'd1;
            end
            gsdw_pkg::DELTA_PLUS: begin
                row_ok = (row_p1 < r_rows_eff);
                nb_row = r_cur_row + 6'd1;
            end
            default: begin
                row_ok = 1'b1;
                nb_row = r_cur_row;
            end
        endcase
        case (dc)
            gsdw_pkg::DELTA_MINUS: begin
                col_ok = (r_cur_col != '0);
                nb_col = r_cur_col - 6'd1;
            end
            gsdw_pkg::DELTA_PLUS: begin
                col_ok = (col_p1 < r_cols_eff);
                nb_col = r_cur_col + 6'd1;
            end
            default: begin
                col_ok = 1'b1;
                nb_col = r_cur_col;
            end
        endcase
        nb_ok = row_ok && col_ok;
    end

    always_comb begin
        ram_we = 1'b0;
        if (i_cmd.load) begin
            ram_we   = load_ok;
            ram_addr = cell_addr(i_row_index, i_col_index);
        end else if (i_cmd.scan) begin
            ram_addr = cell_addr(nb_row, nb_col);
        end else begin
            ram_addr = cell_addr(r_cur_row, r_cur_col);
        end
    end

    gsdw_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_height_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (HEIGHT_BITS'(i_elevation)),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_eff  <= ROW_CAP;
            r_cols_eff  <= COL_CAP;
            r_trace     <= 1'b0;
            r_max_steps <= 6'd63;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gsdw_pkg::CFG_GRID_ROWS:  r_rows_eff  <= clamp_dim(i_cfg_data, ROW_CAP);
                gsdw_pkg::CFG_GRID_COLS:  r_cols_eff  <= clamp_dim(i_cfg_data, COL_CAP);
                gsdw_pkg::CFG_TRACE_MODE: r_trace     <= i_cfg_data[0];
                gsdw_pkg::CFG_MAX_STEPS:  r_max_steps <= i_cfg_data[gsdw_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid  <= 1'b0;
            r_pend_center <= 1'b0;
        end else begin
            r_pend_valid  <= i_cmd.rd_center || (i_cmd.scan && nb_ok);
            r_pend_center <= i_cmd.rd_center;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_row <= nb_row;
        r_pend_col <= nb_col;
        if (i_cmd.start) begin
            r_cur_row  <= i_row_index;
            r_cur_col  <= i_col_index;
            r_best_row <= i_row_index;
            r_best_col <= i_col_index;
            r_moves    <= '0;
        end else if (i_cmd.move) begin
            r_cur_row <= r_best_row;
            r_cur_col <= r_best_col;
            r_cur_h   <= r_best_h;
            r_moves   <= r_moves + 6'd1;
        end
        if (r_pend_valid) begin
            if (r_pend_center) begin
                r_cur_h  <= ram_rdata;
                r_best_h <= ram_rdata;
            end else if (ram_rdata < r_best_h) begin
                r_best_row <= r_pend_row;
                r_best_col <= r_pend_col;
                r_best_h   <= ram_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != gsdw_pkg::EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != gsdw_pkg::EMIT_NONE) begin
            r_out_row <= r_cur_row;
            r_out_col <= r_cur_col;
            case (i_cmd.emit)
                gsdw_pkg::EMIT_FAULT: begin
                    r_out_h     <= '0;
                    r_out_steps <= '0;
                    r_out_trunc <= 1'b0;
                    r_out_fault <= 1'b1;
                    r_out_last  <= 1'b1;
                end
                gsdw_pkg::EMIT_TRACE: begin
                    r_out_h     <= gsdw_pkg::ELEV_W'(r_cur_h);
                    r_out_steps <= r_moves;
                    r_out_trunc <= 1'b0;
                    r_out_fault <= 1'b0;
                    r_out_last  <= 1'b0;
                end
                default: begin
                    r_out_h     <= gsdw_pkg::ELEV_W'(r_cur_h);
                    r_out_steps <= r_moves;
                    r_out_trunc <= has_lower;
                    r_out_fault <= 1'b0;
                    r_out_last  <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cell_row    = r_out_row;
    assign o_cell_col    = r_out_col;
    assign o_cell_height = r_out_h;
    assign o_step_count  = r_out_steps;
    assign o_truncated   = r_out_trunc;
    assign o_fault       = r_out_fault;
    assign o_last        = r_out_last;

    a_pend_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> $past(i_cmd.rd_center || i_cmd.scan))
        else $error("compare without an issued memory read");

    a_fault_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_last && !o_truncated && (o_step_count == '0)))
        else $error("malformed fault word");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_truncated) |-> (o_last && !o_fault))
        else $error("truncated flag on a non-final word");

endmodule

`default_nettype wire

// ===== sv/grid_steepest_descent_walk.sv =====
// top level of the grid steepest descent walk
`timescale 1ns / 1ps
`default_nettype none

// Load words write one elevation into the height memory and
// give no result; the whole grid must be loaded before a walk reads it. A walk
// word starts at a cell and steps to the strictly lowest of its eight neighbors
// (nw, w, sw, n, s, ne, e, se, first found wins a tie) until a local minimum or
// max_steps moves. The single-port height memory reads one cell per cycle, so a
// move reads its eight neighbors in turn, drains the last read and then
// decides; trace results and output stalls make a walk longer. A start
// outside the grid gives one fault word. The input stalls while a walk runs;
// results leave through an output register.
module grid_steepest_descent_walk #(
    parameter int MAX_ROWS    = gsdw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = gsdw_pkg::MAX_COLS_DEF,
    parameter int HEIGHT_BITS = gsdw_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_op,
    input  wire logic [gsdw_pkg::ROW_W-1:0]         i_row_index,
    input  wire logic [gsdw_pkg::COL_W-1:0]         i_col_index,
    input  wire logic [gsdw_pkg::ELEV_W-1:0]        i_elevation,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [gsdw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gsdw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic      [gsdw_pkg::ROW_W-1:0]         o_cell_row,
    output logic      [gsdw_pkg::COL_W-1:0]         o_cell_col,
    output logic      [gsdw_pkg::ELEV_W-1:0]        o_cell_height,
    output logic      [gsdw_pkg::STEP_W-1:0]        o_step_count,
    output logic                                    o_truncated,
    output logic                                    o_fault,
    output logic                                    o_last
);

    gsdw_pkg::t_dp_cmd  cmd;
    gsdw_pkg::t_dp_stat stat;

    gsdw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gsdw_dpath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_elevation   (i_elevation),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .o_cell_height (o_cell_height),
        .o_step_count  (o_step_count),
        .o_truncated   (o_truncated),
        .o_fault       (o_fault),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire
